>>> rtl/stq_pkg.sv
// shared types, constants and codes of the sorted timer queue
`default_nettype none
package stq_pkg;

	localparam int SLOTS = 64;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);

	localparam int NOW_W = 48;
	localparam int TGT_W = 49;
	localparam int DLY_W = 32;
	localparam int ID_W  = 48;
	localparam int CFG_W = 32;
	localparam int CIX_W = 2;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_FIRE   = 2'd2,
		KIND_SUM    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_MIN_DELAY = 2'd0,
		REG_MAX_FIRES = 2'd1,
		REG_MIN_WAIT  = 2'd2,
		REG_MAX_WAIT  = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDXM1,
		RD_IDXP1,
		RD_TOP
	} rd_sel_t;

	typedef enum logic {
		WR_INS,
		WR_RDATA
	} wr_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_I_CHK,
		ST_I_CMP,
		ST_EMIT_C,
		ST_D_CHK,
		ST_D_CMP,
		ST_S_CHK,
		ST_S_WR,
		ST_EMIT_D,
		ST_T_CHK,
		ST_T_CMP,
		ST_T_FIRE,
		ST_T_SUM
	} state_t;

	typedef struct packed {
		logic [TGT_W-1:0] target;
		logic [DLY_W-1:0] interval;
		logic [ID_W-1:0]  ident;
		logic             once;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic    latch;
		logic    c_new;
		logic    ok_set;
		logic    ok_val;
		logic    idx_zero;
		logic    idx_inc;
		logic    idx_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_dec;
		logic    cnt_inc_idx;
		logic    fires_clr;
		logic    fire_take;
		logic    out_ld;
		kind_t   out_sel;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic count_zero;
		logic idx_zero;
		logic idx_at_count;
		logic idx_last;
		logic fire_ok;
		logic rd_lt;
		logic rd_late;
		logic id_match;
		logic ins_once;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> rtl/stq_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module stq_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/stq_dp.sv
// datapath: configuration, timer table, counters and result register
`default_nettype none
module stq_dp
	import stq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CIX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic [1:0]       command,
	input  wire logic [NOW_W-1:0] now_ms,
	input  wire logic [DLY_W-1:0] delay_ms,
	input  wire logic             one_shot,
	input  wire logic [ID_W-1:0]  target_id,
	input  wire ctrl_t            ctl,
	output stat_t                 st,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            kind,
	output logic [ID_W-1:0]       result_id,
	output logic                  ok,
	output logic [DLY_W-1:0]      wait_ms,
	output logic                  table_empty,
	output logic                  last
);

	logic [15:0]      min_delay_q;
	logic [5:0]       max_fires_q;
	logic [15:0]      min_wait_q;
	logic [31:0]      max_wait_q;

	cmd_t             cmd_q;
	logic [NOW_W-1:0] now_q;
	logic [DLY_W-1:0] del_q;
	logic             once_q;
	logic [ID_W-1:0]  tid_q;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [ID_W-1:0]  nid_q;
	logic [5:0]       fires_q;
	logic             ok_q;
	entry_t           ins_q;

	logic [CW-1:0]    idx_m1;
	logic [CW-1:0]    idx_p1;
	logic [CW-1:0]    cnt_m1;
	logic [AW-1:0]    raddr;
	entry_t           wdata;
	entry_t           rdata;
	logic [ENTRY_W-1:0] rdata_raw;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [ID_W-1:0]  id_q;
	logic             ok_out_q;
	logic [DLY_W-1:0] wait_q;
	logic             empty_q;
	logic             last_q;

	logic [TGT_W-1:0] now_x;
	logic [TGT_W-1:0] diff;
	logic [DLY_W-1:0] wait_c;
	logic             out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= 16'd1;
			max_fires_q <= 6'd10;
			min_wait_q  <= 16'd1;
			max_wait_q  <= 32'd60000;
		end else if (cfg_we) begin
			unique case (reg_t'(cfg_index))
				REG_MIN_DELAY: min_delay_q <= cfg_data[15:0];
				REG_MAX_FIRES: max_fires_q <= cfg_data[5:0];
				REG_MIN_WAIT:  min_wait_q  <= cfg_data[15:0];
				REG_MAX_WAIT:  max_wait_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input beat capture, delay clamped up to the minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_NONE;
		end else if (ctl.latch) begin
			cmd_q <= cmd_t'(command);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			now_q  <= now_ms;
			del_q  <= (delay_ms < {16'd0, min_delay_q}) ? {16'd0, min_delay_q} : delay_ms;
			once_q <= one_shot;
			tid_q  <= target_id;
		end
	end

	assign idx_m1 = idx_q - CW'(1);
	assign idx_p1 = idx_q + CW'(1);
	assign cnt_m1 = count_q - CW'(1);
	assign now_x  = {1'b0, now_q};

	// counters and indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			nid_q   <= ID_W'(1);
			fires_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			if (ctl.c_new) begin
				nid_q   <= nid_q + ID_W'(1);
				idx_q   <= count_q;
				count_q <= count_q + CW'(1);
			end
			if (ctl.cnt_inc_idx) begin
				idx_q   <= count_q;
				count_q <= count_q + CW'(1);
			end
			if (ctl.cnt_dec || ctl.fire_take) begin
				count_q <= cnt_m1;
			end
			if (ctl.idx_zero) idx_q <= '0;
			if (ctl.idx_inc)  idx_q <= idx_p1;
			if (ctl.idx_dec)  idx_q <= idx_m1;
			if (ctl.fires_clr) fires_q <= '0;
			if (ctl.fire_take) fires_q <= fires_q + 6'd1;
			if (ctl.ok_set)    ok_q <= ctl.ok_val;
		end
	end

	// entry being inserted: a new timer or a reinserted interval timer
	always_ff @(posedge clk) begin
		if (ctl.c_new) begin
			ins_q <= '{target:   now_x + TGT_W'(del_q),
			           interval: del_q,
			           ident:    nid_q,
			           once:     once_q};
		end else if (ctl.fire_take) begin
			ins_q <= '{target:   now_x + TGT_W'(rdata.interval),
			           interval: rdata.interval,
			           ident:    rdata.ident,
			           once:     rdata.once};
		end
	end

	// table read address and write data
	always_comb begin
		case (ctl.rd_sel)
			RD_IDX:   raddr = idx_q[AW-1:0];
			RD_IDXM1: raddr = idx_m1[AW-1:0];
			RD_IDXP1: raddr = idx_p1[AW-1:0];
			default:  raddr = cnt_m1[AW-1:0];
		endcase
		wdata = (ctl.wr_sel == WR_INS) ? ins_q : rdata;
	end

	stq_ram #(
		.W (ENTRY_W),
		.D (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (idx_q[AW-1:0]),
		.wdata (wdata),
		.re    (ctl.rd_en),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	assign rdata = entry_t'(rdata_raw);

	// clamped wait to the earliest target
	assign diff = rdata.target - now_x;
	always_comb begin
		if (rdata.target <= now_x || diff < TGT_W'(min_wait_q)) begin
			wait_c = {16'd0, min_wait_q};
		end else if (diff > TGT_W'(max_wait_q)) begin
			wait_c = max_wait_q;
		end else begin
			wait_c = diff[DLY_W-1:0];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			kind_q   <= ctl.out_sel;
			id_q     <= '0;
			ok_out_q <= 1'b0;
			wait_q   <= '0;
			empty_q  <= 1'b0;
			last_q   <= 1'b1;
			case (ctl.out_sel)
				KIND_CREATE: begin
					id_q     <= ok_q ? ins_q.ident : '0;
					ok_out_q <= ok_q;
				end
				KIND_DELETE: begin
					ok_out_q <= ok_q;
				end
				KIND_FIRE: begin
					id_q   <= ins_q.ident;
					last_q <= 1'b0;
				end
				default: begin
					empty_q <= (count_q == '0);
					wait_q  <= (count_q == '0) ? '0 : wait_c;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign result_id   = id_q;
	assign ok          = ok_out_q;
	assign wait_ms     = wait_q;
	assign table_empty = empty_q;
	assign last        = last_q;

	// status to the controller
	always_comb begin
		st.cmd          = cmd_q;
		st.full         = (count_q == CW'(SLOTS));
		st.count_zero   = (count_q == '0);
		st.idx_zero     = (idx_q == '0);
		st.idx_at_count = (idx_q == count_q);
		st.idx_last     = (idx_p1 == count_q);
		st.fire_ok      = (fires_q < max_fires_q);
		st.rd_lt        = (rdata.target < ins_q.target);
		st.rd_late      = (rdata.target > now_x);
		st.id_match     = (rdata.ident == tid_q);
		st.ins_once     = ins_q.once;
		st.out_free     = out_free;
	end

	// table never overfills
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("timer count beyond table size");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |-> out_free)
		else $error("result register overwritten");

	// ids advance only when a timer is created
	a_nid_step: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.c_new |=> $stable(nid_q))
		else $error("id counter moved without a create");

	// writes stay inside the table
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> idx_q < CW'(SLOTS))
		else $error("table write past its end");

endmodule
`default_nettype wire

>>> rtl/stq_ctrl.sv
// controller: sequences create, delete and tick over the timer table
`default_nettype none
module stq_ctrl
	import stq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t st,
	output ctrl_t      ctl
);

	state_t state_q;
	state_t state_d;
	state_t ins_done;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ins_done = (st.cmd == CMD_CREATE) ? ST_EMIT_C : ST_T_CHK;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.rd_sel  = RD_IDX;
		ctl.wr_sel  = WR_INS;
		ctl.out_sel = KIND_CREATE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (st.cmd)
					CMD_CREATE: begin
						ctl.ok_set = 1'b1;
						if (st.full) begin
							state_d = ST_EMIT_C;
						end else begin
							ctl.ok_val = 1'b1;
							ctl.c_new  = 1'b1;
							state_d    = ST_I_CHK;
						end
					end
					CMD_DELETE: begin
						ctl.idx_zero = 1'b1;
						state_d      = ST_D_CHK;
					end
					CMD_TICK: begin
						ctl.fires_clr = 1'b1;
						state_d       = ST_T_CHK;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			// sorted insert: shift earlier targets up one slot
			ST_I_CHK: begin
				if (st.idx_zero) begin
					ctl.wr_en = 1'b1;
					state_d   = ins_done;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDXM1;
					state_d    = ST_I_CMP;
				end
			end
			ST_I_CMP: begin
				ctl.wr_en = 1'b1;
				if (st.rd_lt) begin
					ctl.wr_sel  = WR_RDATA;
					ctl.idx_dec = 1'b1;
					state_d     = ST_I_CHK;
				end else begin
					state_d = ins_done;
				end
			end
			ST_EMIT_C: begin
				if (st.out_free) begin
					ctl.out_ld  = 1'b1;
					ctl.out_sel = KIND_CREATE;
					state_d     = ST_IDLE;
				end
			end
			// delete: search by id, then close the gap
			ST_D_CHK: begin
				if (st.idx_at_count) begin
					ctl.ok_set = 1'b1;
					state_d    = ST_EMIT_D;
				end else begin
					ctl.rd_en = 1'b1;
					state_d   = ST_D_CMP;
				end
			end
			ST_D_CMP: begin
				if (st.id_match) begin
					state_d = ST_S_CHK;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = ST_D_CHK;
				end
			end
			ST_S_CHK: begin
				if (st.idx_last) begin
					ctl.cnt_dec = 1'b1;
					ctl.ok_set  = 1'b1;
					ctl.ok_val  = 1'b1;
					state_d     = ST_EMIT_D;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDXP1;
					state_d    = ST_S_WR;
				end
			end
			ST_S_WR: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_sel  = WR_RDATA;
				ctl.idx_inc = 1'b1;
				state_d     = ST_S_CHK;
			end
			ST_EMIT_D: begin
				if (st.out_free) begin
					ctl.out_ld  = 1'b1;
					ctl.out_sel = KIND_DELETE;
					state_d     = ST_IDLE;
				end
			end
			// tick: fire from the top while due and under the limit
			ST_T_CHK: begin
				ctl.rd_sel = RD_TOP;
				ctl.rd_en  = !st.count_zero;
				state_d    = (st.fire_ok && !st.count_zero) ? ST_T_CMP : ST_T_SUM;
			end
			ST_T_CMP: begin
				if (st.rd_late) begin
					state_d = ST_T_SUM;
				end else begin
					ctl.fire_take = 1'b1;
					state_d       = ST_T_FIRE;
				end
			end
			ST_T_FIRE: begin
				if (st.out_free) begin
					ctl.out_ld  = 1'b1;
					ctl.out_sel = KIND_FIRE;
					if (st.ins_once) begin
						state_d = ST_T_CHK;
					end else begin
						ctl.cnt_inc_idx = 1'b1;
						state_d         = ST_I_CHK;
					end
				end
			end
			ST_T_SUM: begin
				if (st.out_free) begin
					ctl.out_ld  = 1'b1;
					ctl.out_sel = KIND_SUM;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// a new beat is only taken from idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.latch |=> state_q == ST_DISPATCH)
		else $error("input taken outside idle");

	// the table is never read and written from the same state slot by chance
	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.rd_en && ctl.wr_en))
		else $error("table read and write in one cycle");

	// a fire is always followed by more work, never by idle
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_ld && ctl.out_sel == KIND_FIRE) |-> state_d != ST_IDLE)
		else $error("tick ended on a fire result");

endmodule
`default_nettype wire

>>> rtl/sorted_timer_queue.sv
// top level of the sorted timer queue
//
//  channel | signals                                          | dir
//  input   | in_valid in_ready command now_ms delay_ms        | in
//          | one_shot target_id                               |
//  result  | out_valid out_ready kind result_id ok wait_ms    | out
//          | table_empty last                                 |
//  config  | cfg_we cfg_index cfg_data                        | in
//
// create: the sorted insert walks down from the end of the table, moving each
// earlier target up a slot until the new one fits; a full table skips the walk
// delete: a search by id, then later entries move down a slot to close the gap
// tick: fires each due timer from the top and reinserts interval timers by an
// insert walk; every step is set by the single read port of the timer table
// reset leaves the table contents unset; only occupied slots are ever read
// the result register lets the next beat in while the last result waits
`default_nettype none
module sorted_timer_queue
	import stq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CIX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       command,
	input  wire logic [NOW_W-1:0] now_ms,
	input  wire logic [DLY_W-1:0] delay_ms,
	input  wire logic             one_shot,
	input  wire logic [ID_W-1:0]  target_id,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            kind,
	output logic [ID_W-1:0]       result_id,
	output logic                  ok,
	output logic [DLY_W-1:0]      wait_ms,
	output logic                  table_empty,
	output logic                  last
);

	ctrl_t ctl;
	stat_t st;

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.ctl      (ctl)
	);

	stq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (command),
		.now_ms      (now_ms),
		.delay_ms    (delay_ms),
		.one_shot    (one_shot),
		.target_id   (target_id),
		.ctl         (ctl),
		.st          (st),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.result_id   (result_id),
		.ok          (ok),
		.wait_ms     (wait_ms),
		.table_empty (table_empty),
		.last        (last)
	);

endmodule
`default_nettype wire

>>> tb/sv/sorted_timer_queue_tb.sv
// testbench of the sorted timer queue: random and directed beats checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module sorted_timer_queue_tb
	import stq_pkg::*;
();

	typedef struct {
		cmd_t             cmd;
		logic [NOW_W-1:0] now;
		logic [DLY_W-1:0] delay;
		logic             once;
		logic [ID_W-1:0]  tid;
	} timer_cmd_t;

	typedef struct {
		kind_t            kind;
		logic [ID_W-1:0]  id;
		logic             ok;
		logic [DLY_W-1:0] wait_v;
		logic             empty;
		logic             last;
	} timer_res_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CIX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       kind;
	logic [ID_W-1:0]  result_id;
	logic             ok;
	logic [DLY_W-1:0] wait_ms;
	logic             table_empty;
	logic             last;

	timer_cmd_t cur_cmd = '{CMD_NONE, '0, '0, 1'b0, '0};
	timer_cmd_t cmd_pending[$];
	timer_res_t res_expected[$];

	// predictor state and register copies
	logic [TGT_W-1:0] p_target[SLOTS];
	logic [DLY_W-1:0] p_interval[SLOTS];
	logic [ID_W-1:0]  p_ident[SLOTS];
	logic             p_once[SLOTS];
	int               p_live = 0;
	logic [ID_W-1:0]  p_next_id = 1;
	logic [15:0]      p_min_delay = 1;
	logic [5:0]       p_max_fires = 10;
	logic [15:0]      p_min_wait = 1;
	logic [31:0]      p_max_wait = 60000;

	int  n_create = 0, n_delete = 0, n_tick = 0, n_fire = 0, n_full = 0, n_checked = 0;
	int  n_bad = 0;
	bit  no_idle = 0;
	int  in_gap = 0, out_gap = 0;
	logic [NOW_W-1:0] gen_now = 100;
	logic [ID_W-1:0]  gen_ids = 0;

	wire logic [1:0]       command   = cur_cmd.cmd;
	wire logic [NOW_W-1:0] now_ms    = cur_cmd.now;
	wire logic [DLY_W-1:0] delay_ms  = cur_cmd.delay;
	wire logic             one_shot  = cur_cmd.once;
	wire logic [ID_W-1:0]  target_id = cur_cmd.tid;

	sorted_timer_queue i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .now_ms(now_ms), .delay_ms(delay_ms),
		.one_shot(one_shot), .target_id(target_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .result_id(result_id), .ok(ok), .wait_ms(wait_ms),
		.table_empty(table_empty), .last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic swap_slot(int a, int b);
		logic [TGT_W-1:0] t;
		logic [DLY_W-1:0] v;
		logic [ID_W-1:0]  d;
		logic             o;
		t = p_target[a];   p_target[a] = p_target[b];     p_target[b] = t;
		v = p_interval[a]; p_interval[a] = p_interval[b]; p_interval[b] = v;
		d = p_ident[a];    p_ident[a] = p_ident[b];       p_ident[b] = d;
		o = p_once[a];     p_once[a] = p_once[b];         p_once[b] = o;
	endtask

	// sorted insert: append then sink past earlier targets
	task automatic insert_timer(logic [TGT_W-1:0] tgt, logic [DLY_W-1:0] iv,
			logic [ID_W-1:0] id, logic once);
		int i;
		if (p_live >= SLOTS) return;
		p_target[p_live] = tgt;
		p_interval[p_live] = iv;
		p_ident[p_live] = id;
		p_once[p_live] = once;
		p_live++;
		i = p_live - 1;
		while (i > 0 && p_target[i] > p_target[i-1]) begin
			swap_slot(i, i - 1);
			i--;
		end
	endtask

	task automatic push_res(kind_t k, logic [ID_W-1:0] id, logic okv,
			logic [DLY_W-1:0] w, logic e, logic l);
		res_expected.push_back('{k, id, okv, w, e, l});
	endtask

	// expected results of one accepted command beat
	task automatic predict_timer_cmd(timer_cmd_t c);
		logic [DLY_W-1:0] d;
		logic [TGT_W-1:0] n49, tgt, diff;
		logic [DLY_W-1:0] w;
		int fires, top, i;
		bit found;
		n49 = {1'b0, c.now};
		case (c.cmd)
			CMD_CREATE: begin
				n_create++;
				if (p_live >= SLOTS) begin
					n_full++;
					push_res(KIND_CREATE, '0, 1'b0, '0, 1'b0, 1'b1);
				end else begin
					d = c.delay;
					if (d < {16'd0, p_min_delay}) d = {16'd0, p_min_delay};
					insert_timer(n49 + {17'd0, d}, d, p_next_id, c.once);
					push_res(KIND_CREATE, p_next_id, 1'b1, '0, 1'b0, 1'b1);
					p_next_id = p_next_id + 1;
				end
			end
			CMD_DELETE: begin
				n_delete++;
				found = 0;
				for (i = 0; i < p_live; i++) begin
					if (!found && p_ident[i] == c.tid) begin
						found = 1;
						for (int j = i; j + 1 < p_live; j++) swap_slot(j, j + 1);
						p_live--;
					end
				end
				push_res(KIND_DELETE, '0, found, '0, 1'b0, 1'b1);
			end
			CMD_TICK: begin
				n_tick++;
				fires = 0;
				while (fires < p_max_fires && p_live > 0) begin
					top = p_live - 1;
					if (p_target[top] > n49) break;
					p_live = top;
					push_res(KIND_FIRE, p_ident[top], 1'b0, '0, 1'b0, 1'b0);
					fires++;
					n_fire++;
					if (!p_once[top])
						insert_timer(n49 + {17'd0, p_interval[top]}, p_interval[top],
							p_ident[top], 1'b0);
				end
				if (p_live == 0) begin
					push_res(KIND_SUM, '0, 1'b0, '0, 1'b1, 1'b1);
				end else begin
					tgt = p_target[p_live-1];
					diff = tgt - n49;
					if (tgt <= n49 || diff < {33'd0, p_min_wait}) w = {16'd0, p_min_wait};
					else if (diff > {17'd0, p_max_wait}) w = p_max_wait;
					else w = diff[DLY_W-1:0];
					push_res(KIND_SUM, '0, 1'b0, w, 1'b0, 1'b1);
				end
			end
			default: ;
		endcase
	endtask

	// driver: presents queued command beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) predict_timer_cmd(cur_cmd);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (cmd_pending.size() > 0 && !no_idle && $urandom_range(0, 5) == 0) begin
					in_gap = $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (cmd_pending.size() > 0) begin
					cur_cmd <= cmd_pending.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random stalls, each result beat checked against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (res_expected.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected result beat: kind %0d id %0h", kind, result_id);
				end else begin
					timer_res_t e;
					e = res_expected.pop_front();
					n_checked++;
					if (kind !== e.kind || result_id !== e.id || ok !== e.ok ||
							wait_ms !== e.wait_v || table_empty !== e.empty || last !== e.last) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch: exp kind %0d id %0h ok %0b wait %0d empty %0b last %0b / got kind %0d id %0h ok %0b wait %0d empty %0b last %0b",
								e.kind, e.id, e.ok, e.wait_v, e.empty, e.last,
								kind, result_id, ok, wait_ms, table_empty, last);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic add_cmd(cmd_t c, logic [NOW_W-1:0] n, logic [DLY_W-1:0] d,
			logic o, logic [ID_W-1:0] t);
		cmd_pending.push_back('{c, n, d, o, t});
		if (c == CMD_CREATE) gen_ids++;
	endtask

	task automatic cfg_write(reg_t r, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_MIN_DELAY: p_min_delay = v[15:0];
			REG_MAX_FIRES: p_max_fires = v[5:0];
			REG_MIN_WAIT:  p_min_wait = v[15:0];
			default:       p_max_wait = v;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(logic [15:0] md, logic [5:0] mf, logic [15:0] mw, logic [31:0] xw);
		cfg_write(REG_MIN_DELAY, {16'd0, md});
		cfg_write(REG_MAX_FIRES, {26'd0, mf});
		cfg_write(REG_MIN_WAIT, {16'd0, mw});
		cfg_write(REG_MAX_WAIT, xw);
	endtask

	// let all beats drain, then allow for a command that gives no result
	task automatic drain;
		do @(posedge clk);
		while (cmd_pending.size() > 0 || in_valid || res_expected.size() > 0);
		repeat (400) @(posedge clk);
	endtask

	// mostly well-formed traffic around a running clock, with some noise
	task automatic gen_random(int n);
		int r;
		logic [DLY_W-1:0] d;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
				add_cmd(CMD_CREATE, gen_now, d, $urandom_range(0, 1), {$urandom, $urandom});
			end else if (r < 55) begin
				add_cmd(CMD_DELETE, {$urandom, $urandom}, $urandom, $urandom_range(0, 1),
					($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
						: ID_W'($urandom_range(1, int'(gen_ids) + 1)));
			end else if (r < 95) begin
				gen_now = gen_now + $urandom_range(0, 30);
				add_cmd(CMD_TICK, gen_now, $urandom, $urandom_range(0, 1), {$urandom, $urandom});
			end else if (r < 98) begin
				add_cmd(CMD_NONE, {$urandom, $urandom}, $urandom, $urandom_range(0, 1),
					{$urandom, $urandom});
			end else begin
				gen_now = {$urandom, $urandom};
				add_cmd(CMD_TICK, gen_now, $urandom, 1'b0, {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: clamps, equal targets, deletes, due and empty ticks, ignored code
		add_cmd(CMD_CREATE, 48'd100, 32'd0, 1'b1, '0);
		add_cmd(CMD_CREATE, 48'd100, 32'hffff_ffff, 1'b0, '1);
		add_cmd(CMD_CREATE, 48'd100, 32'd5, 1'b1, '0);
		add_cmd(CMD_CREATE, 48'd100, 32'd5, 1'b0, '0);
		add_cmd(CMD_TICK, 48'd100, '0, 1'b0, '0);
		add_cmd(CMD_TICK, 48'd105, '0, 1'b0, '0);
		add_cmd(CMD_DELETE, '0, '0, 1'b0, 48'd2);
		add_cmd(CMD_DELETE, '0, '0, 1'b0, 48'hffff_ffff_ffff);
		add_cmd(CMD_NONE, '1, '1, 1'b1, '1);
		add_cmd(CMD_TICK, 48'hffff_ffff_ffff, '1, 1'b1, '1);
		add_cmd(CMD_DELETE, '0, '0, 1'b0, 48'd4);
		add_cmd(CMD_DELETE, '0, '0, 1'b0, 48'd1);
		add_cmd(CMD_TICK, 48'd200, '0, 1'b0, '0);
		drain();

		// tightest clamps, single fire per tick
		set_regs(16'd0, 6'd1, 16'd0, 32'd0);
		gen_random(60);
		drain();

		// widest settings, then fill the table past its capacity
		set_regs(16'hffff, 6'd63, 16'hffff, 32'hffff_ffff);
		for (int k = 0; k < 68; k++)
			add_cmd(CMD_CREATE, gen_now, $urandom_range(0, 300000), $urandom_range(0, 1), '0);
		add_cmd(CMD_DELETE, '0, '0, 1'b0, ID_W'(gen_ids - 3));
		gen_now = gen_now + 70000;
		add_cmd(CMD_TICK, gen_now, '0, 1'b0, '0);
		add_cmd(CMD_TICK, gen_now + 400000, '0, 1'b0, '0);
		drain();

		// no fires allowed at all
		set_regs(16'd3, 6'd0, 16'd2, 32'd50);
		gen_random(30);
		drain();

		// random settings
		set_regs($urandom_range(0, 20), $urandom_range(1, 63), $urandom_range(0, 10),
			$urandom_range(5, 100));
		gen_random(100);
		drain();

		// reset values again, no idling to the end
		set_regs(16'd1, 6'd10, 16'd1, 32'd60000);
		no_idle = 1;
		gen_random(90);
		drain();

		$display("covered %0d creates (%0d on a full table), %0d deletes, %0d ticks",
			n_create, n_full, n_delete, n_tick);
		$display("%0d timers fired, %0d result beats checked, %0d mismatches",
			n_fire, n_checked, n_bad);
		if (n_bad == 0 && res_expected.size() == 0) begin
			$display("** sorted_timer_queue: PASSED **");
		end else begin
			$display("** sorted_timer_queue: FAILED **");
		end
		$finish;
	end

	initial begin
		#500_000_000;
		$display("timeout");
		$display("** sorted_timer_queue: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
